// File: hw/rtl/fur_pkg.sv
// fur_pkg: shared widths, codes, reset values and handshake structs for the
// framed uart receiver. No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package fur_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // result status codes
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd0;
  localparam logic [STAT_W-1:0] ST_OK         = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_CRC    = 3'd4;
  localparam logic [STAT_W-1:0] ST_TIMEOUT    = 3'd5;

  // parser phases
  localparam logic [PHASE_W-1:0] PH_MAGIC0  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_MAGIC1  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CRC_LO  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CRC_HI  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS   = 3'd4;

  // configuration reset values
  localparam logic [BYTE_W-1:0] MAGIC_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] MAGIC_SECOND_RST = 8'd85;
  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST   = 7'd1;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 7'd64;
  localparam logic [TIME_W-1:0] TIMEOUT_MS_RST   = 32'd100;

  // crc-16/ccitt-false
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // controller to datapath
  typedef struct packed {
    logic latch_in;  // capture the accepted request
    logic eval;      // run the parser on the captured byte
    logic rd_step;   // push one payload byte of a good frame
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic frame_ok;  // captured byte closes a frame with a good crc
    logic rd_last;   // current readout byte is the final one
  } stat_t;

  // one byte through the msb-first crc register
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/fur_in_if.sv
// fur_in_if: request channel carrying one received byte and its timestamp.
// Depends on fur_pkg for field widths.
`timescale 1ns / 1ps

interface fur_in_if;
  logic                        valid;
  logic                        ready;
  logic [fur_pkg::BYTE_W-1:0]  rx_byte;
  logic [fur_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output rx_byte, output now_ms, input ready);
  modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

// File: hw/rtl/fur_out_if.sv
// fur_out_if: result channel carrying status, payload byte, length and last mark.
// Depends on fur_pkg for field widths.
`timescale 1ns / 1ps

interface fur_out_if;
  logic                        valid;
  logic                        ready;
  logic [fur_pkg::STAT_W-1:0]  status;
  logic [fur_pkg::BYTE_W-1:0]  data_byte;
  logic [fur_pkg::LEN_W-1:0]   payload_length;
  logic                        last;

  modport source (output valid, output status, output data_byte,
                  output payload_length, output last, input ready);
  modport sink   (input valid, input status, input data_byte,
                  input payload_length, input last, output ready);
endinterface

// File: hw/rtl/fur_ctrl.sv
// fur_ctrl: sequencer for capture, parse and payload readout.
// Depends on fur_pkg (cmd_t, stat_t).
`timescale 1ns / 1ps

module fur_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fur_pkg::stat_t stat_i,
  output fur_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.out_free) begin
          cmd_o.eval = 1'b1;
          state_d    = stat_i.frame_ok ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        if (stat_i.out_free) begin
          cmd_o.rd_step = 1'b1;
          if (stat_i.rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/fur_dp.sv
// fur_dp: parser registers, crc, payload buffer, config registers and result register.
// Depends on fur_pkg; driven by fur_ctrl through cmd_t / stat_t.
`timescale 1ns / 1ps

module fur_dp #(
  parameter int unsigned MAX_PAYLOAD = fur_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fur_pkg::cmd_t                  cmd_i,
  output fur_pkg::stat_t                 stat_o,
  input  logic [fur_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic [fur_pkg::TIME_W-1:0]     now_ms_i,
  input  logic                           cfg_we_i,
  input  logic [fur_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fur_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [fur_pkg::STAT_W-1:0]     out_status_o,
  output logic [fur_pkg::BYTE_W-1:0]     out_data_o,
  output logic [fur_pkg::LEN_W-1:0]      out_len_o,
  output logic                           out_last_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned BW = fur_pkg::BYTE_W;
  localparam int unsigned LW = fur_pkg::LEN_W;
  localparam int unsigned TW = fur_pkg::TIME_W;
  localparam int unsigned CW = fur_pkg::CRC_W;
  localparam int unsigned PW = fur_pkg::PHASE_W;
  localparam int unsigned SW = fur_pkg::STAT_W;

  // config
  logic [BW-1:0] magic_first_q, magic_second_q;
  logic [LW-1:0] min_len_q, max_len_q;
  logic [TW-1:0] timeout_q;

  // captured request
  logic [BW-1:0] rx_q;
  logic [TW-1:0] now_q;

  // parser state
  logic [PW-1:0] phase_q, phase_d;
  logic [TW-1:0] last_time_q, last_time_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] exp_q, exp_d;
  logic [CW-1:0] crc_q, crc_d;
  logic [BW-1:0] crc_lo_q, crc_lo_d;
  logic [LW-1:0] rd_idx_q;

  // result register
  logic          out_valid_q;
  logic [SW-1:0] out_status_q;
  logic [BW-1:0] out_data_q;
  logic [LW-1:0] out_len_q;
  logic          out_last_q;

  logic [BW-1:0] mem [MAX_PAYLOAD];

  logic          frame_stale;
  logic [TW-1:0] gap;
  logic [8:0]    len_hi;
  logic [PW-1:0] eff_phase;
  logic [SW-1:0] proc_st, res_st;
  logic          frame_ok;
  logic          mem_we;
  logic [LW-1:0] cnt_inc;
  logic          rd_last;
  logic          out_free;
  logic          load_eval;
  logic [AW-1:0] wr_addr, rd_addr;

  assign gap         = now_q - last_time_q;
  assign frame_stale = (phase_q != fur_pkg::PH_MAGIC0) && (gap > timeout_q);
  assign eff_phase   = frame_stale ? fur_pkg::PH_MAGIC0 : phase_q;
  assign len_hi      = (int'(max_len_q) < MAX_PAYLOAD) ? {2'b00, max_len_q}
                                                       : 9'(MAX_PAYLOAD);
  assign cnt_inc     = cnt_q + LW'(1);
  assign wr_addr     = AW'(cnt_q);
  assign rd_addr     = AW'(rd_idx_q);
  assign rd_last     = ((rd_idx_q + LW'(1)) == exp_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_eval   = cmd_i.eval && !frame_ok;

  assign stat_o.out_free = out_free;
  assign stat_o.frame_ok = frame_ok;
  assign stat_o.rd_last  = rd_last;

  // parser step; a timeout first puts the parser back to its reset values
  always_comb begin
    phase_d     = eff_phase;
    last_time_d = frame_stale ? '0 : last_time_q;
    cnt_d       = frame_stale ? '0 : cnt_q;
    exp_d       = frame_stale ? '0 : exp_q;
    crc_d       = frame_stale ? fur_pkg::CRC_INIT : crc_q;
    crc_lo_d    = frame_stale ? '0 : crc_lo_q;
    proc_st     = fur_pkg::ST_EMPTY;
    frame_ok    = 1'b0;
    mem_we      = 1'b0;
    unique case (eff_phase)
      fur_pkg::PH_MAGIC0: begin
        if (rx_q == magic_first_q) begin
          phase_d     = fur_pkg::PH_MAGIC1;
          last_time_d = now_q;
        end
      end
      fur_pkg::PH_MAGIC1: begin
        last_time_d = now_q;
        if (rx_q == magic_second_q) begin
          phase_d = fur_pkg::PH_LENGTH;
        end else if (rx_q != magic_first_q) begin
          phase_d = fur_pkg::PH_MAGIC0;
        end
      end
      fur_pkg::PH_LENGTH: begin
        last_time_d = now_q;
        if (({1'b0, rx_q} > len_hi) || (rx_q < {1'b0, min_len_q}) || (rx_q == '0)) begin
          proc_st  = ({1'b0, rx_q} > len_hi) ? fur_pkg::ST_TOO_LARGE
                                             : fur_pkg::ST_BAD_LENGTH;
          phase_d     = fur_pkg::PH_MAGIC0;
          last_time_d = '0;
          cnt_d       = '0;
          exp_d       = '0;
          crc_d       = fur_pkg::CRC_INIT;
          crc_lo_d    = '0;
          // resync when the rejected length looks like a first magic
          if (rx_q == magic_first_q) begin
            phase_d     = fur_pkg::PH_MAGIC1;
            last_time_d = now_q;
          end
        end else begin
          exp_d   = rx_q[LW-1:0];
          cnt_d   = '0;
          crc_d   = fur_pkg::crc_feed(fur_pkg::CRC_INIT, rx_q);
          phase_d = fur_pkg::PH_PAYLOAD;
        end
      end
      fur_pkg::PH_PAYLOAD: begin
        last_time_d = now_q;
        mem_we      = (int'(cnt_q) < MAX_PAYLOAD);
        cnt_d       = cnt_inc;
        crc_d       = fur_pkg::crc_feed(crc_q, rx_q);
        if (cnt_inc >= exp_q) begin
          phase_d = fur_pkg::PH_CRC_LO;
        end
      end
      fur_pkg::PH_CRC_LO: begin
        last_time_d = now_q;
        crc_lo_d    = rx_q;
        phase_d     = fur_pkg::PH_CRC_HI;
      end
      fur_pkg::PH_CRC_HI: begin
        if ({rx_q, crc_lo_q} == crc_q) begin
          // state is held for the readout and cleared after its last byte
          frame_ok = 1'b1;
        end else begin
          proc_st     = fur_pkg::ST_BAD_CRC;
          phase_d     = fur_pkg::PH_MAGIC0;
          last_time_d = '0;
          cnt_d       = '0;
          exp_d       = '0;
          crc_d       = fur_pkg::CRC_INIT;
          crc_lo_d    = '0;
        end
      end
      default: begin
        phase_d     = fur_pkg::PH_MAGIC0;
        last_time_d = '0;
        cnt_d       = '0;
        exp_d       = '0;
        crc_d       = fur_pkg::CRC_INIT;
        crc_lo_d    = '0;
      end
    endcase
    res_st = frame_stale ? fur_pkg::ST_TIMEOUT : proc_st;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q  <= fur_pkg::MAGIC_FIRST_RST;
      magic_second_q <= fur_pkg::MAGIC_SECOND_RST;
      min_len_q      <= fur_pkg::MIN_LENGTH_RST;
      max_len_q      <= fur_pkg::MAX_LENGTH_RST;
      timeout_q      <= fur_pkg::TIMEOUT_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fur_pkg::CFG_MAGIC_FIRST:  magic_first_q  <= cfg_wdata_i[BW-1:0];
        fur_pkg::CFG_MAGIC_SECOND: magic_second_q <= cfg_wdata_i[BW-1:0];
        fur_pkg::CFG_MIN_LENGTH:   min_len_q      <= cfg_wdata_i[LW-1:0];
        fur_pkg::CFG_MAX_LENGTH:   max_len_q      <= cfg_wdata_i[LW-1:0];
        fur_pkg::CFG_TIMEOUT_MS:   timeout_q      <= cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      rx_q  <= rx_byte_i;
      now_q <= now_ms_i;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fur_pkg::PH_MAGIC0;
      last_time_q <= '0;
      cnt_q       <= '0;
      exp_q       <= '0;
      crc_q       <= fur_pkg::CRC_INIT;
      crc_lo_q    <= '0;
      rd_idx_q    <= '0;
    end else if (cmd_i.eval) begin
      phase_q     <= phase_d;
      last_time_q <= last_time_d;
      cnt_q       <= cnt_d;
      exp_q       <= exp_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
      rd_idx_q    <= '0;
    end else if (cmd_i.rd_step) begin
      rd_idx_q <= rd_idx_q + LW'(1);
      if (rd_last) begin
        phase_q     <= fur_pkg::PH_MAGIC0;
        last_time_q <= '0;
        cnt_q       <= '0;
        exp_q       <= '0;
        crc_q       <= fur_pkg::CRC_INIT;
        crc_lo_q    <= '0;
      end
    end
  end

  // payload buffer, its read port lands straight in the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && mem_we) begin
      mem[wr_addr] <= rx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_step) begin
      out_status_q <= fur_pkg::ST_OK;
      out_data_q   <= mem[rd_addr];
      out_len_q    <= exp_q;
      out_last_q   <= rd_last;
    end else if (load_eval) begin
      out_status_q <= res_st;
      out_data_q   <= '0;
      out_len_q    <= '0;
      out_last_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_step || load_eval) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_len_o    = out_len_q;
  assign out_last_o   = out_last_q;

endmodule

// File: hw/rtl/framed_uart_receiver_crc16.sv
// framed_uart_receiver_crc16: top level, joins sequencer and datapath.
// Depends on fur_pkg, fur_in_if, fur_out_if, fur_ctrl and fur_dp.
//
// usage
//   rx_i carries one received byte with its millisecond timestamp per request.
//   the parser hunts for two magic bytes, takes a length byte, buffers the
//   payload and checks a little-endian crc-16/ccitt-false over length+payload.
//   res_o returns one result per request (status, last set), except that the
//   byte closing a frame with a good crc returns the whole payload as a run of
//   ok results, last set on the final byte.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the five config registers; write them
//   only while no request is in flight.
// request flow
//   an accepted request is captured first, then parsed into the output
//   register once it is free; no new request is taken until the parse is done.
//   a good frame reads out of the payload buffer at one byte per cycle while
//   res_o is not stalled, during which no request is taken.
// reset
//   rst_ni clears the parser to the magic hunt and the config to its defaults;
//   the payload buffer is not cleared and needs no clearing pass.
// stall
//   when res_o is stalled the result waits in the output register; outside a
//   readout one more request is still captured, parsed once the register is free.
`timescale 1ns / 1ps

module framed_uart_receiver_crc16 #(
  parameter int unsigned MAX_PAYLOAD = fur_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fur_in_if.sink                         rx_i,
  fur_out_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [fur_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fur_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // command and status between sequencer and datapath
  fur_pkg::cmd_t  cmd;
  fur_pkg::stat_t stat;
  logic           in_ready;

  fur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // request is taken only while the sequencer sits idle
  assign rx_i.ready = in_ready;

  fur_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rx_byte_i    (rx_i.rx_byte),
    .now_ms_i     (rx_i.now_ms),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_status_o (res_o.status),
    .out_data_o   (res_o.data_byte),
    .out_len_o    (res_o.payload_length),
    .out_last_o   (res_o.last)
  );

endmodule

// File: sim/framed_uart_receiver_crc16_tb.sv
// framed_uart_receiver_crc16_tb: self-checking bench for the framed uart receiver,
// directed and random traffic against a frame decoder scoreboard with its own parser.
// Depends on fur_pkg, fur_in_if, fur_out_if and framed_uart_receiver_crc16.
`timescale 1ns / 1ps

typedef struct packed {
  logic [fur_pkg::STAT_W-1:0] status;
  logic [fur_pkg::BYTE_W-1:0] data_byte;
  logic [fur_pkg::LEN_W-1:0]  payload_length;
  logic                       last;
} frame_result_t;

class frame_decoder_scoreboard;
  logic [fur_pkg::BYTE_W-1:0]  magic_first;
  logic [fur_pkg::BYTE_W-1:0]  magic_second;
  logic [fur_pkg::LEN_W-1:0]   min_length;
  logic [fur_pkg::LEN_W-1:0]   max_length;
  logic [fur_pkg::TIME_W-1:0]  timeout_ms;

  logic [fur_pkg::PHASE_W-1:0] phase;
  logic [fur_pkg::TIME_W-1:0]  last_time;
  logic [fur_pkg::BYTE_W-1:0]  payload [fur_pkg::MAX_PAYLOAD_DEF];
  logic [fur_pkg::LEN_W-1:0]   count;
  logic [fur_pkg::LEN_W-1:0]   length;
  logic [fur_pkg::CRC_W-1:0]   crc;
  logic [fur_pkg::BYTE_W-1:0]  crc_low;

  frame_result_t               pending [$];
  int unsigned                 errors;

  function new();
    magic_first  = fur_pkg::MAGIC_FIRST_RST;
    magic_second = fur_pkg::MAGIC_SECOND_RST;
    min_length   = fur_pkg::MIN_LENGTH_RST;
    max_length   = fur_pkg::MAX_LENGTH_RST;
    timeout_ms   = fur_pkg::TIMEOUT_MS_RST;
    errors       = 0;
    clear_parser();
  endfunction

  function void clear_parser();
    phase     = fur_pkg::PH_MAGIC0;
    last_time = '0;
    count     = '0;
    length    = '0;
    crc       = fur_pkg::CRC_INIT;
    crc_low   = '0;
    foreach (payload[i]) payload[i] = '0;
  endfunction

  // bit-serial crc-16, msb first, poly 0x1021
  static function logic [fur_pkg::CRC_W-1:0] crc_byte(logic [fur_pkg::CRC_W-1:0] c,
                                                      logic [fur_pkg::BYTE_W-1:0] b);
    logic [fur_pkg::CRC_W-1:0] r;
    r = c;
    for (int i = fur_pkg::BYTE_W - 1; i >= 0; i--) begin
      if (r[fur_pkg::CRC_W-1] ^ b[i]) begin
        r = (r << 1) ^ fur_pkg::CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  // one byte through the frame parser, returns the status it yields
  function logic [fur_pkg::STAT_W-1:0] parse(logic [fur_pkg::BYTE_W-1:0] b,
                                             logic [fur_pkg::TIME_W-1:0] now);
    int unsigned hi;
    hi = (max_length < fur_pkg::MAX_PAYLOAD_DEF) ? max_length : fur_pkg::MAX_PAYLOAD_DEF;
    unique case (phase)
      fur_pkg::PH_MAGIC0: begin
        if (b == magic_first) begin
          phase     = fur_pkg::PH_MAGIC1;
          last_time = now;
        end
        return fur_pkg::ST_EMPTY;
      end
      fur_pkg::PH_MAGIC1: begin
        last_time = now;
        if (b == magic_second) begin
          phase = fur_pkg::PH_LENGTH;
        end else if (b != magic_first) begin
          phase = fur_pkg::PH_MAGIC0;
        end
        return fur_pkg::ST_EMPTY;
      end
      fur_pkg::PH_LENGTH: begin
        last_time = now;
        if (b > hi || b < min_length || b == 0) begin
          // too large is tested first, a first magic resyncs
          clear_parser();
          if (b == magic_first) begin
            phase     = fur_pkg::PH_MAGIC1;
            last_time = now;
          end
          return (b > hi) ? fur_pkg::ST_TOO_LARGE : fur_pkg::ST_BAD_LENGTH;
        end
        length = b[fur_pkg::LEN_W-1:0];
        count  = '0;
        crc    = crc_byte(fur_pkg::CRC_INIT, b);
        phase  = fur_pkg::PH_PAYLOAD;
        return fur_pkg::ST_EMPTY;
      end
      fur_pkg::PH_PAYLOAD: begin
        last_time = now;
        if (count < fur_pkg::MAX_PAYLOAD_DEF) payload[count] = b;
        count = count + 1'b1;
        crc   = crc_byte(crc, b);
        if (count >= length) phase = fur_pkg::PH_CRC_LO;
        return fur_pkg::ST_EMPTY;
      end
      fur_pkg::PH_CRC_LO: begin
        last_time = now;
        crc_low   = b;
        phase     = fur_pkg::PH_CRC_HI;
        return fur_pkg::ST_EMPTY;
      end
      fur_pkg::PH_CRC_HI: begin
        if ({b, crc_low} != crc) begin
          clear_parser();
          return fur_pkg::ST_BAD_CRC;
        end
        return fur_pkg::ST_OK;
      end
      default: begin
        clear_parser();
        return fur_pkg::ST_EMPTY;
      end
    endcase
  endfunction

  function void note_request(logic [fur_pkg::BYTE_W-1:0] b, logic [fur_pkg::TIME_W-1:0] now);
    logic [fur_pkg::TIME_W-1:0] gap;
    logic [fur_pkg::STAT_W-1:0] st;
    int unsigned                n;
    gap = now - last_time;
    if (phase != fur_pkg::PH_MAGIC0 && gap > timeout_ms) begin
      // stale frame: restart the hunt with this byte, its own status dropped
      clear_parser();
      void'(parse(b, now));
      pending.push_back(frame_result_t'{fur_pkg::ST_TIMEOUT, 8'h00, 7'd0, 1'b1});
      return;
    end
    st = parse(b, now);
    if (st == fur_pkg::ST_OK) begin
      n = (length > fur_pkg::MAX_PAYLOAD_DEF) ? fur_pkg::MAX_PAYLOAD_DEF : length;
      for (int k = 0; k < n; k++) begin
        pending.push_back(frame_result_t'{fur_pkg::ST_OK, payload[k],
                                          n[fur_pkg::LEN_W-1:0], (k + 1 == n)});
      end
      clear_parser();
    end else begin
      pending.push_back(frame_result_t'{st, 8'h00, 7'd0, 1'b1});
    end
  endfunction

  function void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: result with none expected, got status %0d data %0d length %0d last %0d",
               $time, got.status, got.data_byte, got.payload_length, got.last);
      errors++;
      return;
    end
    want = pending.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("data_byte", want.data_byte, got.data_byte);
    compare_field("payload_length", want.payload_length, got.payload_length);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module framed_uart_receiver_crc16_tb;

  // cycles with no request or result moving before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // quiet cycles after the last result, before a register write or the end
  localparam int unsigned SETTLE_CYCLES  = 4;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [fur_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fur_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  fur_in_if  rx_if ();
  fur_out_if res_if ();

  framed_uart_receiver_crc16 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  frame_decoder_scoreboard sb;

  // millisecond clock of the link, advanced per sent byte
  logic [fur_pkg::TIME_W-1:0] link_time;
  // idle odds in percent for the sender and the result side
  int unsigned                send_idle_pct;
  int unsigned                stall_pct;
  int unsigned                bytes_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request and result monitor, plus random back-pressure on the result side;
  // all handshake signals are sampled with their pre-edge values
  always @(posedge clk_i) begin
    if (rx_if.valid && rx_if.ready) begin
      sb.note_request(rx_if.rx_byte, rx_if.now_ms);
    end
    if (res_if.valid && res_if.ready) begin
      sb.check_result(frame_result_t'{res_if.status, res_if.data_byte,
                                      res_if.payload_length, res_if.last});
    end
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // hang detector: nothing accepted on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("framed_uart_receiver_crc16_tb: done, errors");
    $finish;
  end

  // one request; late pushes the timestamp past the inter-byte limit,
  // otherwise the gap stays within it and sometimes sits right on it
  task automatic send_byte(logic [fur_pkg::BYTE_W-1:0] b, bit late);
    logic [fur_pkg::TIME_W-1:0] tmo;
    tmo = sb.timeout_ms;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    if (late) begin
      link_time = link_time + tmo + 1 + $urandom_range(0, 7);
    end else if ($urandom_range(0, 9) == 0) begin
      link_time = link_time + tmo;
    end else begin
      link_time = link_time + $urandom_range(0, (tmo < 40) ? tmo : 40);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.now_ms  <= link_time;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  // magic pair, length, random payload and crc for the current register set;
  // a length outside 1 to 64 gets no payload or crc
  task automatic send_frame(logic [fur_pkg::BYTE_W-1:0] len_byte, bit bad_crc, int late_at,
                            bit dup_magic);
    logic [fur_pkg::BYTE_W-1:0] body [$];
    logic [fur_pkg::CRC_W-1:0]  c;
    int unsigned                n;
    body = {sb.magic_first};
    if (dup_magic) body.push_back(sb.magic_first);
    body.push_back(sb.magic_second);
    body.push_back(len_byte);
    n = (len_byte >= 1 && len_byte <= fur_pkg::MAX_PAYLOAD_DEF) ? len_byte : 0;
    c = fur_pkg::crc_feed(fur_pkg::CRC_INIT, len_byte);
    repeat (n) begin
      body.push_back(8'($urandom_range(0, 255)));
      c = fur_pkg::crc_feed(c, body[$]);
    end
    if (n != 0) begin
      if (bad_crc) c ^= 16'h0001 << $urandom_range(0, 15);
      // crc goes out low byte first
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
    end
    foreach (body[i]) send_byte(body[i], i == late_at);
  endtask

  // sender holds off until every expected result is back and the block is quiet
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [fur_pkg::CFG_IDX_W-1:0] idx,
                           logic [fur_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // all five registers, in the block and in the scoreboard copy
  task automatic configure(logic [fur_pkg::BYTE_W-1:0] mf, logic [fur_pkg::BYTE_W-1:0] ms,
                           logic [fur_pkg::LEN_W-1:0] lo, logic [fur_pkg::LEN_W-1:0] hi,
                           logic [fur_pkg::TIME_W-1:0] tmo);
    write_reg(fur_pkg::CFG_MAGIC_FIRST, fur_pkg::CFG_DATA_W'(mf));
    write_reg(fur_pkg::CFG_MAGIC_SECOND, fur_pkg::CFG_DATA_W'(ms));
    write_reg(fur_pkg::CFG_MIN_LENGTH, fur_pkg::CFG_DATA_W'(lo));
    write_reg(fur_pkg::CFG_MAX_LENGTH, fur_pkg::CFG_DATA_W'(hi));
    write_reg(fur_pkg::CFG_TIMEOUT_MS, tmo);
    cfg_we_i        <= 1'b0;
    sb.magic_first  = mf;
    sb.magic_second = ms;
    sb.min_length   = lo;
    sb.max_length   = hi;
    sb.timeout_ms   = tmo;
  endtask

  initial begin : stimulus
    int unsigned                r;
    int unsigned                lo;
    int unsigned                hi;
    int unsigned                target;
    logic [fur_pkg::BYTE_W-1:0] len_byte;

    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    rx_if.now_ms  <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    link_time     = $urandom;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset registers, no idling

    // first magic then a stranger drops back to the hunt
    send_byte(fur_pkg::MAGIC_FIRST_RST, 1'b0);
    send_byte(8'h00, 1'b0);
    // length byte equal to the first magic: too large with resync, then a
    // repeated first magic that holds the hunt, then a good one-byte frame
    send_byte(fur_pkg::MAGIC_FIRST_RST, 1'b0);
    send_byte(fur_pkg::MAGIC_SECOND_RST, 1'b0);
    send_frame(8'd1, 1'b0, -1, 1'b1);
    // one past the largest length
    send_frame(8'd65, 1'b0, -1, 1'b0);
    // flipped crc bit
    send_frame(8'd2, 1'b1, -1, 1'b0);
    // gap past the limit on a first magic: timeout, and the byte restarts
    // the hunt; then a zero length, always refused
    send_byte(fur_pkg::MAGIC_FIRST_RST, 1'b0);
    send_byte(fur_pkg::MAGIC_FIRST_RST, 1'b1);
    send_byte(fur_pkg::MAGIC_SECOND_RST, 1'b0);
    send_byte(8'h00, 1'b0);

    // random part: one register set and one idling mode per pass
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      unique case (ph)
        0: configure(fur_pkg::MAGIC_FIRST_RST, fur_pkg::MAGIC_SECOND_RST,
                     fur_pkg::MIN_LENGTH_RST, fur_pkg::MAX_LENGTH_RST,
                     fur_pkg::TIMEOUT_MS_RST);
        // zero timeout: any nonzero gap inside a frame is stale
        1: configure(8'h00, 8'hFF, 7'd1, 7'd1, 32'd0);
        // only full 64-byte frames, no timeout possible
        2: configure(8'hFF, 8'h00, 7'd64, 7'd64, 32'hFFFF_FFFF);
        // equal magics, and a first magic that is itself a short length
        3: configure(8'd3, 8'd3, 7'd10, 7'd20, 32'd1000);
        // min above max: every length is turned away
        4: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 7'd20, 7'd10,
                     $urandom_range(0, 300));
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           7'($urandom_range(1, 8)), 7'($urandom_range(8, 64)),
                           $urandom_range(0, 500));
      endcase
      unique case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 61;
        end
        default: begin
          send_idle_pct = 11;
          stall_pct     = 11;
        end
      endcase
      // the long-frame pass also rides the timestamp through its wrap
      if (ph == 2) begin
        link_time = 32'hFFFF_FF00;
      end else begin
        link_time = $urandom;
      end
      target = bytes_sent + ((ph == 2) ? 60 : 20);

      while (bytes_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          // line noise
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          lo = sb.min_length;
          hi = (sb.max_length < fur_pkg::MAX_PAYLOAD_DEF) ? sb.max_length
                                                          : fur_pkg::MAX_PAYLOAD_DEF;
          if ($urandom_range(0, 9) == 0) begin
            len_byte = 8'($urandom_range(0, 255));
          end else if (lo > hi) begin
            len_byte = 8'($urandom_range(0, 70));
          end else if ($urandom_range(0, 7) == 0) begin
            len_byte = 8'(hi);
          end else begin
            len_byte = 8'($urandom_range(lo, (lo + 7 < hi) ? lo + 7 : hi));
          end
          // mostly well-formed frames; some with a bad crc, a stale byte
          // early in the frame, or a repeated first magic
          send_frame(len_byte, r < 24, (r >= 24 && r < 34) ? $urandom_range(1, 4) : -1,
                     r >= 90);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("framed_uart_receiver_crc16_tb: done, clean");
    end else begin
      $display("framed_uart_receiver_crc16_tb: done, errors");
    end
    $finish;
  end

endmodule
